>>> src/assert_macros.svh
// Assertion macros for the framed ring queue.
// Used by the top level; expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define FRQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("framed ring queue check failed");

// Check that a trigger implies a consequence in the same cycle.
`define FRQ_ASSERT_IMPL(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("framed ring queue check failed");

`endif

>>> src/frq_pkg.sv
// Shared types, constants and pointer helpers of the framed ring queue.
// No dependencies.
package frq_pkg;

  localparam int CHANNELS   = 8;
  localparam int RING_BYTES = 1024;
  localparam int MAX_FRAME  = 63;
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int PTR_W      = $clog2(RING_BYTES);
  localparam int QS_W       = 11;
  localparam int CC_W       = 4;
  localparam int ADDR_W     = CH_W + PTR_W;
  localparam int DEPTH      = CHANNELS * RING_BYTES;
  localparam int FRM_W      = 10;
  localparam int TOT_W      = 13;
  localparam logic [QS_W-1:0] QS_MIN   = QS_W'(MAX_FRAME + 3);
  localparam logic [QS_W-1:0] QS_MAX   = QS_W'(RING_BYTES);
  localparam logic [CC_W-1:0] CC_MAX   = CC_W'(CHANNELS);
  localparam logic [CC_W-1:0] CC_MIN   = CC_W'(1);

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP        = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_BAD_CHAN  = 3'd3,
    ST_OVER_LIM  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    K_PUSH_LEN  = 2'd0,
    K_PUSH_BYTE = 2'd1,
    K_POP       = 2'd2,
    K_BAD_OP    = 2'd3
  } kind_t;

  typedef enum logic {
    REG_QUEUE_SIZE    = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  channel;
    logic        first_of_frame;
    logic [7:0]  frame_length;
    logic [7:0]  data_byte;
    logic [15:0] pop_limit;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       out_byte;
    logic [7:0]       popped_length;
    logic             last_result;
    logic [FRM_W-1:0] channel_frames;
    logic [TOT_W-1:0] total_frames;
  } rsp_t;

  typedef struct packed {
    kind_t kind;
    req_t  item;
  } entry_t;

  typedef struct packed {
    logic            clear;
    logic [QS_W-1:0] queue_size;
    logic [CC_W-1:0] channel_count;
  } cfg_t;

  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [8:0] a,
                                               input logic [QS_W-1:0] qs);
    logic [QS_W:0] s;
    s = {2'b00, p} + {3'b000, a};
    if (s >= {1'b0, qs}) s = s - {1'b0, qs};
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_sub(input logic [PTR_W-1:0] p,
                                               input logic [8:0] a,
                                               input logic [QS_W-1:0] qs);
    logic [QS_W:0] s;
    s = {2'b00, p} + {1'b0, qs} - {3'b000, a};
    if (s >= {1'b0, qs}) s = s - {1'b0, qs};
    return s[PTR_W-1:0];
  endfunction

endpackage

>>> src/frq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> src/frq_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on frq_pkg.
module frq_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  frq_pkg::req_t    req,
  output logic             q_valid,
  output frq_pkg::entry_t  q_entry,
  input  logic             q_take
);

  frq_pkg::entry_t ent [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;
  frq_pkg::kind_t  kind;

  always_comb begin
    unique case (frq_pkg::op_t'(req.operation))
      frq_pkg::OP_POP:  kind = frq_pkg::K_POP;
      frq_pkg::OP_NONE: kind = frq_pkg::K_BAD_OP;
      default:          kind = req.first_of_frame ? frq_pkg::K_PUSH_LEN
                                                  : frq_pkg::K_PUSH_BYTE;
    endcase
  end

  assign req_stall = (count == 2'd2);
  assign push      = req_valid && !req_stall;
  assign q_valid   = (count != 2'd0);
  assign pop       = q_valid && q_take;
  assign q_entry   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) ent[wr_ptr] <= '{kind: kind, item: req};
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> src/frq_back.sv
// Back end: carries out pushes, evictions and pops on the ring store.
// Depends on frq_pkg and frq_ram; holds the output register.
module frq_back (
  input  logic             clk,
  input  logic             rst,
  input  frq_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  frq_pkg::entry_t  q_entry,
  output logic             q_take,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output frq_pkg::rsp_t    rsp
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVICT  = 5'b00010,
    S_PLACE  = 5'b00100,
    S_POPLEN = 5'b01000,
    S_POPB   = 5'b10000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [frq_pkg::PTR_W-1:0]       head [frq_pkg::CHANNELS];
  logic [frq_pkg::PTR_W-1:0]       tail [frq_pkg::CHANNELS];
  logic [frq_pkg::FRM_W-1:0]       frames [frq_pkg::CHANNELS];
  logic [frq_pkg::PTR_W-1:0]       fill_ptr;
  logic [7:0]                      pending;
  logic                            rejected;
  logic [frq_pkg::CH_W-1:0]        fill_ch;
  frq_pkg::req_t                   cur;
  logic [frq_pkg::QS_W:0]          fr;
  logic [7:0]                      rem;
  logic [7:0]                      plen;

  logic                            out_free;
  logic                            emit;
  frq_pkg::status_t                e_status;
  logic [7:0]                      e_byte;
  logic [7:0]                      e_plen;
  logic                            e_last;
  logic                            e_inc;
  logic                            e_dec;
  logic [frq_pkg::CH_W-1:0]        e_ch;
  logic [frq_pkg::TOT_W-1:0]       total;

  logic                            we;
  logic [frq_pkg::ADDR_W-1:0]      waddr;
  logic [7:0]                      wdata;
  logic                            re;
  logic [frq_pkg::ADDR_W-1:0]      raddr;
  logic [7:0]                      rdata;

  frq_pkg::req_t                   qi;
  logic [frq_pkg::CH_W-1:0]        qch;
  logic [frq_pkg::CH_W-1:0]        cch;
  logic                            q_in_use;
  logic [frq_pkg::QS_W:0]          q_free;
  logic [8:0]                      need;
  logic [8:0]                      step;
  logic [frq_pkg::QS_W:0]          fr_n;
  logic [frq_pkg::PTR_W-1:0]       ev_head;
  logic [frq_pkg::FRM_W-1:0]       ev_frames;
  logic [frq_pkg::PTR_W-1:0]       base_head;
  logic [frq_pkg::PTR_W-1:0]       front_head;
  logic [frq_pkg::PTR_W-1:0]       next_head;

  frq_ram #(.WIDTH(8), .DEPTH(frq_pkg::DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free = !rsp_valid || !rsp_stall;
  assign qi       = q_entry.item;
  assign qch      = qi.channel;
  assign cch      = cur.channel;
  assign q_in_use = {1'b0, qch} < cfg.channel_count;
  assign need     = {1'b0, cur.frame_length} + 9'd2;
  assign q_free   = (tail[qch] >= head[qch])
                  ? {1'b0, cfg.queue_size} - {2'b00, tail[qch]} + {2'b00, head[qch]}
                  : {2'b00, head[qch]} - {2'b00, tail[qch]};
  assign step     = {1'b0, rdata} + 9'd1;
  assign fr_n     = fr + {3'b000, step};
  assign ev_head  = frq_pkg::ptr_add(head[cch], step, cfg.queue_size);
  assign ev_frames = frames[cch] - frq_pkg::FRM_W'(1);
  assign base_head = (frames[cch] == '0) ? tail[cch] : head[cch];
  assign front_head = frq_pkg::ptr_sub(base_head, {1'b0, cur.frame_length} + 9'd1,
                                       cfg.queue_size);
  assign next_head = frq_pkg::ptr_add(head[cch], 9'd1, cfg.queue_size);

  always_comb begin
    logic [frq_pkg::TOT_W-1:0] s;
    s = '0;
    for (int c = 0; c < frq_pkg::CHANNELS; c++) begin
      if (c < int'(cfg.channel_count)) s = s + frq_pkg::TOT_W'(frames[c]);
    end
    total = s;
  end

  always_comb begin
    state_next = state;
    q_take   = 1'b0;
    emit     = 1'b0;
    e_status = frq_pkg::ST_OK;
    e_byte   = 8'd0;
    e_plen   = 8'd0;
    e_last   = 1'b1;
    e_inc    = 1'b0;
    e_dec    = 1'b0;
    e_ch     = cch;
    we       = 1'b0;
    waddr    = {fill_ch, fill_ptr};
    wdata    = qi.data_byte;
    re       = 1'b0;
    raddr    = {qch, head[qch]};
    unique case (state)
      S_IDLE: begin
        e_ch = qch;
        if (q_valid && out_free) begin
          q_take = 1'b1;
          unique case (q_entry.kind)
            frq_pkg::K_BAD_OP: begin
              emit = 1'b1;
              e_status = frq_pkg::ST_BAD_LEN;
            end
            frq_pkg::K_POP: begin
              if (!q_in_use) begin
                emit = 1'b1;
                e_status = frq_pkg::ST_BAD_CHAN;
              end else if (frames[qch] == '0) begin
                emit = 1'b1;
                e_status = frq_pkg::ST_EMPTY;
              end else begin
                re = 1'b1;
                state_next = S_POPLEN;
              end
            end
            frq_pkg::K_PUSH_LEN: begin
              if (qi.frame_length == 8'd0 || qi.frame_length > 8'(frq_pkg::MAX_FRAME)) begin
                emit = 1'b1;
                e_status = frq_pkg::ST_BAD_LEN;
              end else if (!q_in_use) begin
                emit = 1'b1;
                e_status = frq_pkg::ST_BAD_CHAN;
              end else if (q_free < {3'b000, qi.frame_length} + 12'd2
                           && frames[qch] != '0) begin
                re = 1'b1;
                state_next = S_EVICT;
              end else begin
                state_next = S_PLACE;
              end
            end
            default: begin
              emit = 1'b1;
              if (pending == 8'd0 || rejected) begin
                e_status = frq_pkg::ST_BAD_LEN;
              end else begin
                we = 1'b1;
              end
            end
          endcase
        end
      end
      S_EVICT: begin
        if (fr_n < {3'b000, need} && ev_frames != '0) begin
          re = 1'b1;
          raddr = {cch, ev_head};
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        if (out_free) begin
          emit  = 1'b1;
          e_inc = 1'b1;
          we    = 1'b1;
          wdata = cur.frame_length;
          waddr = (cur.operation == frq_pkg::OP_PUSH_BACK) ? {cch, tail[cch]}
                                                           : {cch, front_head};
          state_next = S_IDLE;
        end
      end
      S_POPLEN: begin
        if (out_free) begin
          if (rdata == 8'd0 || rdata > 8'(frq_pkg::MAX_FRAME)) begin
            emit = 1'b1;
            e_status = frq_pkg::ST_BAD_LEN;
            state_next = S_IDLE;
          end else if ({8'd0, rdata} > cur.pop_limit) begin
            emit = 1'b1;
            e_status = frq_pkg::ST_OVER_LIM;
            e_plen = rdata;
            state_next = S_IDLE;
          end else begin
            re = 1'b1;
            raddr = {cch, next_head};
            state_next = S_POPB;
          end
        end
      end
      S_POPB: begin
        if (out_free) begin
          emit   = 1'b1;
          e_byte = rdata;
          e_plen = plen;
          e_last = (rem == 8'd1);
          e_dec  = e_last;
          if (e_last) begin
            state_next = S_IDLE;
          end else begin
            re = 1'b1;
            raddr = {cch, next_head};
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.status        <= e_status;
      rsp.out_byte      <= e_byte;
      rsp.popped_length <= e_plen;
      rsp.last_result   <= e_last;
      if ({1'b0, e_ch} < cfg.channel_count) begin
        rsp.channel_frames <= frames[e_ch] + frq_pkg::FRM_W'(e_inc) - frq_pkg::FRM_W'(e_dec);
      end else begin
        rsp.channel_frames <= '0;
      end
      rsp.total_frames <= total + frq_pkg::TOT_W'(e_inc) - frq_pkg::TOT_W'(e_dec);
    end
    if (state == S_IDLE && q_take) cur <= qi;
    if (state == S_POPLEN && state_next == S_POPB) rem <= rdata;
    if (state == S_POPLEN && state_next == S_POPB) plen <= rdata;
    if (state == S_POPB && emit) rem <= rem - 8'd1;
    if (state == S_IDLE) fr <= q_free;
    else if (state == S_EVICT) fr <= fr_n;

    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= emit ? 1'b1 : (rsp_valid && rsp_stall);
    end

    if (rst || cfg.clear) begin
      for (int c = 0; c < frq_pkg::CHANNELS; c++) begin
        head[c]   <= '0;
        tail[c]   <= '0;
        frames[c] <= '0;
      end
      fill_ptr <= '0;
      pending  <= 8'd0;
      rejected <= 1'b0;
      fill_ch  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid && out_free && q_entry.kind == frq_pkg::K_PUSH_LEN) begin
            pending <= 8'd0;
            if (qi.frame_length == 8'd0 || qi.frame_length > 8'(frq_pkg::MAX_FRAME)
                || !q_in_use) begin
              rejected <= 1'b1;
            end
          end else if (we) begin
            fill_ptr <= frq_pkg::ptr_add(fill_ptr, 9'd1, cfg.queue_size);
            pending  <= pending - 8'd1;
          end
        end
        S_EVICT: begin
          head[cch]   <= ev_head;
          frames[cch] <= ev_frames;
        end
        S_PLACE: begin
          if (emit) begin
            if (cur.operation == frq_pkg::OP_PUSH_BACK) begin
              head[cch] <= base_head;
              fill_ptr  <= frq_pkg::ptr_add(tail[cch], 9'd1, cfg.queue_size);
              tail[cch] <= frq_pkg::ptr_add(tail[cch], {1'b0, cur.frame_length} + 9'd1,
                                            cfg.queue_size);
            end else begin
              head[cch] <= front_head;
              fill_ptr  <= frq_pkg::ptr_add(front_head, 9'd1, cfg.queue_size);
            end
            frames[cch] <= frames[cch] + frq_pkg::FRM_W'(1);
            fill_ch     <= cch;
            pending     <= cur.frame_length;
            rejected    <= 1'b0;
          end
        end
        S_POPLEN: begin
          if (state_next == S_POPB) head[cch] <= next_head;
        end
        S_POPB: begin
          if (emit) begin
            head[cch] <= next_head;
            if (e_dec) frames[cch] <= ev_frames;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/framed_ring_queue.sv
// Framed ring queue: length-prefixed frames held in per-channel byte rings.
// Requests enter on req (valid/stall), results leave on rsp (valid/stall).
// Registers: queue_size at byte address 0, channel_count at byte address 4.
// A push is one request per byte: the first carries frame_length, and frees
// room by evicting the oldest frames of the ring when space runs short.
// Each push byte and each rejected request gives one result.
// A pop gives one result per payload byte, last_result set on the final one,
// or a single status result.
// A payload push byte or a request rejected on arrival gives its result in
// the cycle after the back end takes it. A length byte goes through S_EVICT,
// evicting a frame per registered RAM read while room is short, then S_PLACE.
// A pop checks its length in S_POPLEN, then one byte per cycle unless stalled.
// A two-entry request queue separates the front end from the back end;
// req_stall rises only when that queue is full.
// When rsp_stall meets a valid result, it holds and the back end waits to emit.
// Reset empties all rings, sets queue_size to 1024 and channel_count to 8;
// the ring RAM needs no clearing pass. A queue_size write also empties rings.
// Depends on frq_pkg, frq_front, frq_back and assert_macros.svh.
`include "assert_macros.svh"

module framed_ring_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  frq_pkg::req_t         req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output frq_pkg::rsp_t         rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic                          q_valid;
  frq_pkg::entry_t               q_entry;
  logic                          q_take;
  frq_pkg::cfg_t                 cfg;
  logic [frq_pkg::QS_W-1:0]      queue_size;
  logic [frq_pkg::CC_W-1:0]      channel_count;
  logic                          wr;
  frq_pkg::reg_idx_t             idx;
  logic [frq_pkg::QS_W-1:0]      qs_in;
  logic [frq_pkg::CC_W-1:0]      cc_in;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = frq_pkg::reg_idx_t'(paddr[2]);
  assign qs_in  = pwdata[frq_pkg::QS_W-1:0];
  assign cc_in  = pwdata[frq_pkg::CC_W-1:0];

  always_comb begin
    unique case (idx)
      frq_pkg::REG_QUEUE_SIZE: prdata = {{(32-frq_pkg::QS_W){1'b0}}, queue_size};
      default:                 prdata = {{(32-frq_pkg::CC_W){1'b0}}, channel_count};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_size    <= frq_pkg::QS_MAX;
      channel_count <= frq_pkg::CC_MAX;
    end else if (wr) begin
      if (idx == frq_pkg::REG_QUEUE_SIZE) begin
        queue_size <= (qs_in < frq_pkg::QS_MIN) ? frq_pkg::QS_MIN
                    : (qs_in > frq_pkg::QS_MAX) ? frq_pkg::QS_MAX : qs_in;
      end else begin
        channel_count <= (cc_in < frq_pkg::CC_MIN) ? frq_pkg::CC_MIN
                       : (cc_in > frq_pkg::CC_MAX) ? frq_pkg::CC_MAX : cc_in;
      end
    end
  end

  assign cfg.clear         = wr && (idx == frq_pkg::REG_QUEUE_SIZE);
  assign cfg.queue_size    = queue_size;
  assign cfg.channel_count = channel_count;

  frq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_take    (q_take)
  );

  frq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_take    (q_take),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `FRQ_ASSERT_IMPL(a_mid_run_ok, rsp_valid && !rsp.last_result, rsp.status == frq_pkg::ST_OK)
  `FRQ_ASSERT_IMPL(a_plen_only_pop, rsp_valid && rsp.status != frq_pkg::ST_OK && rsp.status != frq_pkg::ST_OVER_LIM, rsp.popped_length == 8'd0)
  `FRQ_ASSERT_ALWAYS(a_qs_range, queue_size >= frq_pkg::QS_MIN && queue_size <= frq_pkg::QS_MAX)

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for framed_ring_queue: frame pushes, pops and
// register changes checked against a built-in predictor of the rings.
// Depends on frq_pkg and the framed_ring_queue RTL.
`timescale 1ns / 100ps

module tb_top;
  import frq_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  class ring_scoreboard;
    bit [7:0] mem [CHANNELS][RING_BYTES];
    int head [CHANNELS];
    int tail [CHANNELS];
    int frames [CHANNELS];
    int fill_ptr, pend, rej, fill_ch, qs, cc;
    rsp_t due [$];
    int errors, n_req, n_rsp;

    function new();
      qs = RING_BYTES;
      cc = CHANNELS;
      clear();
    endfunction

    function void clear();
      for (int c = 0; c < CHANNELS; c++) begin
        head[c] = 0;
        tail[c] = 0;
        frames[c] = 0;
      end
      fill_ptr = 0;
      pend = 0;
      rej = 0;
      fill_ch = 0;
    endfunction

    function int clampv(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void cfg_write(reg_idx_t idx, int v);
      if (idx == REG_QUEUE_SIZE) begin
        qs = clampv(v & 'h7FF, MAX_FRAME + 3, RING_BYTES);
        clear();
      end else begin
        cc = clampv(v & 'hF, 1, CHANNELS);
      end
    endfunction

    function bit used(int ch);
      return ch < cc;
    endfunction

    function void add_due(status_t st, int b, int pl, bit last, int ch);
      rsp_t r;
      int sum;
      sum = 0;
      for (int c = 0; c < cc; c++) sum += frames[c];
      r.status = st;
      r.out_byte = b;
      r.popped_length = pl;
      r.last_result = last;
      r.channel_frames = used(ch) ? frames[ch] : 0;
      r.total_frames = sum;
      due.push_back(r);
    endfunction

    function int room(int ch);
      return (tail[ch] >= head[ch]) ? qs - tail[ch] + head[ch] : head[ch] - tail[ch];
    endfunction

    function void note(req_t q);
      int ch, len, lim, fr, stp, h, L;
      ch = q.channel;
      len = q.frame_length;
      lim = q.pop_limit;
      n_req++;
      if (op_t'(q.operation) == OP_NONE) begin
        add_due(ST_BAD_LEN, 0, 0, 1, ch);
      end else if (op_t'(q.operation) == OP_POP) begin
        if (!used(ch)) add_due(ST_BAD_CHAN, 0, 0, 1, ch);
        else if (frames[ch] == 0) add_due(ST_EMPTY, 0, 0, 1, ch);
        else begin
          L = mem[ch][head[ch]];
          if (L == 0 || L > MAX_FRAME) add_due(ST_BAD_LEN, 0, 0, 1, ch);
          else if (L > lim) add_due(ST_OVER_LIM, 0, L, 1, ch);
          else begin
            head[ch] = (head[ch] + 1) % qs;
            for (int i = 0; i < L; i++) begin
              stp = mem[ch][head[ch]];
              head[ch] = (head[ch] + 1) % qs;
              if (i == L - 1) frames[ch]--;
              add_due(ST_OK, stp, L, i == L - 1, ch);
            end
          end
        end
      end else if (q.first_of_frame) begin
        pend = 0;
        if (len == 0 || len > MAX_FRAME) begin
          rej = 1;
          add_due(ST_BAD_LEN, 0, 0, 1, ch);
        end else if (!used(ch)) begin
          rej = 1;
          add_due(ST_BAD_CHAN, 0, 0, 1, ch);
        end else begin
          // evict oldest frames until the new one fits with a margin byte
          fr = room(ch);
          while (fr < len + 2 && frames[ch] > 0) begin
            stp = mem[ch][head[ch]] + 1;
            fr += stp;
            head[ch] = (head[ch] + stp) % qs;
            frames[ch]--;
          end
          if (frames[ch] == 0) head[ch] = tail[ch];
          if (op_t'(q.operation) == OP_PUSH_BACK) begin
            mem[ch][tail[ch]] = len;
            fill_ptr = (tail[ch] + 1) % qs;
            tail[ch] = (tail[ch] + 1 + len) % qs;
          end else begin
            h = (head[ch] + qs - (len + 1)) % qs;
            head[ch] = h;
            mem[ch][h] = len;
            fill_ptr = (h + 1) % qs;
          end
          frames[ch]++;
          fill_ch = ch;
          pend = len;
          rej = 0;
          add_due(ST_OK, 0, 0, 1, ch);
        end
      end else if (pend == 0 || rej) begin
        add_due(ST_BAD_LEN, 0, 0, 1, ch);
      end else begin
        mem[fill_ch][fill_ptr] = q.data_byte;
        fill_ptr = (fill_ptr + 1) % qs;
        pend--;
        add_due(ST_OK, 0, 0, 1, ch);
      end
    endfunction

    function void check(rsp_t a);
      rsp_t e;
      n_rsp++;
      if (due.size() == 0) begin
        $error("unexpected result %p", a);
        errors++;
        return;
      end
      e = due.pop_front();
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status);
        errors++;
      end
      if (a.out_byte !== e.out_byte) begin
        $error("out_byte: expected %0d, got %0d", e.out_byte, a.out_byte);
        errors++;
      end
      if (a.popped_length !== e.popped_length) begin
        $error("popped_length: expected %0d, got %0d", e.popped_length, a.popped_length);
        errors++;
      end
      if (a.last_result !== e.last_result) begin
        $error("last_result: expected %0d, got %0d", e.last_result, a.last_result);
        errors++;
      end
      if (a.channel_frames !== e.channel_frames) begin
        $error("channel_frames: expected %0d, got %0d", e.channel_frames, a.channel_frames);
        errors++;
      end
      if (a.total_frames !== e.total_frames) begin
        $error("total_frames: expected %0d, got %0d", e.total_frames, a.total_frames);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  framed_ring_queue dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ring_scoreboard sb = new();
  int  cycles;
  int  cur_cc;
  int  open_bytes;
  int  open_ch;
  bit  no_idle;
  bit  held;
  int  hold_left;
  int  burst_left;
  int  n_cfg;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** framed_ring_queue: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) sb.note(req);
    if (!rst && rsp_valid && !rsp_stall) sb.check(rsp);
  end

  // receiver: random stall bursts, plus one long hold-off to fill the block
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held && sb.n_req >= 150) begin
      held <= 1'b1;
      hold_left <= 400;
      rsp_stall <= 1'b1;
    end else if (burst_left > 0) begin
      rsp_stall <= 1'b1;
      burst_left <= burst_left - 1;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      rsp_stall <= 1'b1;
      burst_left <= $urandom_range(0, 8);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  function automatic req_t mk(op_t op, int ch, bit f, int len, int db, int lim);
    req_t r;
    r.operation = op;
    r.channel = ch;
    r.first_of_frame = f;
    r.frame_length = len;
    r.data_byte = db;
    r.pop_limit = lim;
    return r;
  endfunction

  // open pushes are always completed, so a pop never meets unfilled bytes
  function automatic req_t rand_req();
    req_t r;
    int pick;
    r.operation = $urandom;
    r.channel = $urandom;
    r.first_of_frame = $urandom;
    r.frame_length = $urandom;
    r.data_byte = $urandom;
    r.pop_limit = $urandom;
    if (open_bytes > 0) begin
      if ($urandom_range(0, 9) < 8) begin
        r.operation = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        r.first_of_frame = 1'b0;
      end else begin
        r.operation = $urandom_range(0, 1) ? OP_POP : OP_NONE;
        if (r.channel == open_ch) r.channel = open_ch ^ 1;
      end
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        r.operation = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        r.first_of_frame = 1'b1;
        r.frame_length = ($urandom_range(0, 3) == 0) ? MAX_FRAME
                                                     : $urandom_range(1, MAX_FRAME);
        r.channel = $urandom_range(0, cur_cc - 1);
      end else if (pick < 16) begin
        r.operation = OP_POP;
        if ($urandom_range(0, 3) != 0) r.channel = $urandom_range(0, cur_cc - 1);
        if ($urandom_range(0, 2) == 0) r.pop_limit = $urandom_range(0, 70);
      end
    end
    return r;
  endfunction

  task automatic send_req(req_t r);
    if (op_t'(r.operation) != OP_POP && op_t'(r.operation) != OP_NONE) begin
      if (r.first_of_frame) begin
        open_bytes = (r.frame_length >= 1 && r.frame_length <= MAX_FRAME &&
                      r.channel < cur_cc) ? r.frame_length : 0;
        open_ch = r.channel;
      end else if (open_bytes > 0) begin
        open_bytes--;
      end
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, int v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.cfg_write(idx, v);
    n_cfg++;
  endtask

  task automatic set_config(int qsv, int ccv);
    drain();
    apb_write(REG_QUEUE_SIZE, qsv);
    apb_write(REG_CHANNEL_COUNT, ccv);
    cur_cc = sb.cc;
    open_bytes = 0;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_req(rand_req());
    while (open_bytes > 0) send_req(rand_req());
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    cur_cc = CHANNELS;
    open_bytes = 0;
    open_ch = 0;
    no_idle = 1'b0;
    held = 1'b0;
    hold_left = 0;
    burst_left = 0;
    n_cfg = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_config(1024, 8);
    send_req(mk(OP_PUSH_BACK, 0, 1, 1, 0, 0));
    send_req(mk(OP_PUSH_BACK, 5, 0, 0, 8'hFF, 0));
    send_req(mk(OP_PUSH_FRONT, 0, 1, 2, 0, 0));
    send_req(mk(OP_PUSH_FRONT, 0, 0, 0, 8'h00, 0));
    send_req(mk(OP_PUSH_BACK, 0, 0, 0, 8'hA5, 0));
    send_req(mk(OP_POP, 0, 0, 0, 0, 0));
    send_req(mk(OP_POP, 0, 0, 0, 0, 16'hFFFF));
    send_req(mk(OP_POP, 0, 0, 0, 0, 1));
    send_req(mk(OP_POP, 0, 0, 0, 0, 16'hFFFF));
    send_req(mk(OP_PUSH_BACK, 1, 1, 0, 0, 0));
    send_req(mk(OP_PUSH_FRONT, 1, 1, MAX_FRAME + 1, 0, 0));
    send_req(mk(OP_PUSH_BACK, 1, 1, 255, 0, 0));
    send_req(mk(OP_PUSH_BACK, 1, 0, 0, 8'h5A, 0));
    send_req(mk(OP_NONE, 7, 1, 255, 8'hFF, 16'hFFFF));
    run_random(35);

    set_config(66, 1);
    send_req(mk(OP_PUSH_BACK, 5, 1, 3, 0, 0));
    send_req(mk(OP_POP, 7, 0, 0, 0, 16'hFFFF));
    send_req(mk(OP_PUSH_BACK, 0, 1, MAX_FRAME, 0, 0));
    run_random(35);

    set_config(2000, 15);
    run_random(35);
    set_config(150, 3);
    run_random(35);
    set_config(10, 0);
    run_random(30);
    set_config(1024, 8);
    no_idle = 1'b1;
    run_random(40);

    drain();
    $display("covered %0d requests and %0d results over %0d register writes",
             sb.n_req, sb.n_rsp, n_cfg);
    $display("including evictions on small rings, front pushes and a long result hold-off");
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("** framed_ring_queue: PASSED **");
    end else begin
      $display("** framed_ring_queue: FAILED **");
    end
    $finish;
  end

endmodule
